FILE: rtl/core/ppa_pkg.sv
`default_nettype none
package ppa_pkg;

  localparam int PAGES = 32;
  localparam int AW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int PW    = $clog2(PAGES + 1);

  localparam logic [7:0] USED_BIT  = 8'h80;
  localparam logic [7:0] LEN_MASK  = 8'h7f;
  localparam logic [7:0] NO_HANDLE = 8'hff;
  localparam logic [6:0] COUNT_MAX = 7'h7f;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_SHRINK = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // one access per cycle: a write when we, else a read
  typedef struct packed {
    logic          en;
    logic          we;
    logic [AW-1:0] addr;
    logic [7:0]    wdata;
  } ppa_mreq_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ppa_sts_t;

  typedef struct packed {
    logic [7:0] handle;
    logic [1:0] status;
    logic [6:0] count;
  } ppa_res_t;

  // span length of a head word at page at: zero counts as one, cut at last page
  function automatic logic [PW-1:0] span_len(input logic [7:0] d, input logic [PW-1:0] at);
    logic [7:0] l8;
    logic [7:0] lim8;
    l8   = d & LEN_MASK;
    lim8 = 8'(PAGES) - 8'(at);
    if (l8 == 8'd0) l8 = 8'd1;
    if (l8 > lim8) l8 = lim8;
    return PW'(l8);
  endfunction

  // bytes rounded up to 256-byte pages, at least one
  function automatic logic [8:0] pages_for(input logic [15:0] bytes);
    logic [8:0] p;
    p = {1'b0, bytes[15:8]} + 9'(bytes[7:0] != 8'd0);
    if (p == 9'd0) p = 9'd1;
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ppa_map.sv
`default_nettype none
module ppa_map (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ppa_pkg::ppa_mreq_t req,
  output logic [7:0]             rdata
);
  import ppa_pkg::*;

  logic [7:0]       mem [PAGES];
  logic [PAGES-1:0] vld;
  logic [7:0]       mem_q;
  logic [7:0]       rst_q;
  logic             vld_q;

  // entries never written read as the reset map
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.en && req.we) begin
      vld[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        mem_q <= mem[req.addr];
        vld_q <= vld[req.addr];
        rst_q <= (req.addr == '0) ? (8'(PAGES) & LEN_MASK) : 8'd1;
      end
    end
  end

  assign rdata = vld_q ? mem_q : rst_q;

endmodule
`default_nettype wire

FILE: rtl/core/ppa_seq.sv
`default_nettype none
module ppa_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        op,
  input  wire logic [7:0]        handle,
  input  wire logic [15:0]       length,
  input  wire logic              take,
  input  wire logic [7:0]        rdata,
  output ppa_pkg::ppa_mreq_t     mreq,
  output ppa_pkg::ppa_sts_t      sts,
  output ppa_pkg::ppa_res_t      res
);
  import ppa_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_A_CHK  = 12'b000000000010,
    S_A_WR2  = 12'b000000000100,
    S_H_CHK  = 12'b000000001000,
    S_H_WR2  = 12'b000000010000,
    S_C_RD   = 12'b000000100000,
    S_C_HEAD = 12'b000001000000,
    S_C_SCAN = 12'b000010000000,
    S_C_WR   = 12'b000100000000,
    S_FIN    = 12'b001000000000,
    S_A_RD   = 12'b010000000000,
    S_H_RD   = 12'b100000000000
  } state_t;

  state_t        state, state_next;
  logic [1:0]    op_q;
  logic [7:0]    hdl, hdl_next;
  logic [8:0]    req, req_next;
  logic [PW-1:0] n, n_next;
  logic [PW-1:0] m, m_next;
  logic [PW-1:0] acc, acc_next;
  logic [AW-1:0] wr2_addr, wr2_addr_next;
  logic [7:0]    wr2_data, wr2_data_next;
  logic [7:0]    res_hdl, res_hdl_next;
  logic [1:0]    status, status_next;
  logic [6:0]    count, count_next;

  logic [PW-1:0] len_n, len_m, len_h;
  logic [PW:0]   sum_n, sum_m, sum_acc;
  logic          used;

  assign len_n   = span_len(rdata, n);
  assign len_m   = span_len(rdata, m);
  assign len_h   = span_len(rdata, PW'(hdl[AW-1:0]));
  assign sum_n   = (PW+1)'(n) + (PW+1)'(len_n);
  assign sum_m   = (PW+1)'(m) + (PW+1)'(len_m);
  assign sum_acc = (PW+1)'(n) + (PW+1)'(acc);
  assign used    = rdata[7];

  always_comb begin
    state_next    = state;
    hdl_next      = hdl;
    req_next      = req;
    n_next        = n;
    m_next        = m;
    acc_next      = acc;
    wr2_addr_next = wr2_addr;
    wr2_data_next = wr2_data;
    res_hdl_next  = res_hdl;
    status_next   = status;
    count_next    = count;
    mreq          = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          hdl_next     = handle;
          req_next     = pages_for(length);
          res_hdl_next = NO_HANDLE;
          status_next  = ST_OK;
          n_next       = '0;
          if (op == OP_ALLOC) begin
            state_next = S_A_RD;
          end else if (op == OP_SHRINK || op == OP_FREE) begin
            if (handle == NO_HANDLE) begin
              status_next = ST_NONE;
              state_next  = S_FIN;
            end else if (handle >= 8'(PAGES)) begin
              status_next = ST_RANGE;
              state_next  = S_FIN;
            end else begin
              state_next = S_H_RD;
            end
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_A_RD: begin
        mreq.en    = 1'b1;
        mreq.addr  = n[AW-1:0];
        state_next = S_A_CHK;
      end
      S_A_CHK: begin
        if (!used && 9'(len_n) >= req) begin
          mreq.en       = 1'b1;
          mreq.we       = 1'b1;
          mreq.addr     = n[AW-1:0];
          mreq.wdata    = {1'b1, req[6:0]};
          res_hdl_next  = 8'(n);
          if (count < COUNT_MAX) count_next = count + 7'd1;
          wr2_addr_next = AW'(9'(n) + req);
          wr2_data_next = {1'b0, 7'(9'(len_n) - req)};
          state_next    = (9'(len_n) > req) ? S_A_WR2 : S_FIN;
        end else if (sum_n >= (PW+1)'(PAGES)) begin
          status_next = ST_NOSPACE;
          state_next  = S_FIN;
        end else begin
          mreq.en   = 1'b1;
          mreq.addr = sum_n[AW-1:0];
          n_next    = PW'(sum_n);
        end
      end
      S_A_WR2, S_H_WR2: begin
        mreq.en    = 1'b1;
        mreq.we    = 1'b1;
        mreq.addr  = wr2_addr;
        mreq.wdata = wr2_data;
        state_next = (state == S_A_WR2) ? S_FIN : S_C_RD;
      end
      S_H_RD: begin
        mreq.en    = 1'b1;
        mreq.addr  = hdl[AW-1:0];
        state_next = S_H_CHK;
      end
      S_H_CHK: begin
        if (op_q == OP_SHRINK) begin
          if (9'(len_h) > req) begin
            mreq.en       = 1'b1;
            mreq.we       = 1'b1;
            mreq.addr     = hdl[AW-1:0];
            mreq.wdata    = {1'b1, req[6:0]};
            wr2_addr_next = AW'(9'(hdl) + req);
            wr2_data_next = {1'b0, 7'(9'(len_h) - req)};
            state_next    = S_H_WR2;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          mreq.en    = 1'b1;
          mreq.we    = 1'b1;
          mreq.addr  = hdl[AW-1:0];
          mreq.wdata = rdata & LEN_MASK;
          if (count != 7'd0) count_next = count - 7'd1;
          state_next = S_C_RD;
        end
      end
      S_C_RD: begin
        mreq.en    = 1'b1;
        mreq.addr  = n[AW-1:0];
        state_next = S_C_HEAD;
      end
      S_C_HEAD: begin
        if (used) begin
          if (sum_n >= (PW+1)'(PAGES)) begin
            state_next = S_FIN;
          end else begin
            mreq.en   = 1'b1;
            mreq.addr = sum_n[AW-1:0];
            n_next    = PW'(sum_n);
          end
        end else begin
          acc_next = len_n;
          m_next   = PW'(sum_n);
          if (sum_n < (PW+1)'(PAGES)) begin
            mreq.en    = 1'b1;
            mreq.addr  = sum_n[AW-1:0];
            state_next = S_C_SCAN;
          end else begin
            state_next = S_C_WR;
          end
        end
      end
      S_C_SCAN: begin
        if (used) begin
          state_next = S_C_WR;
        end else begin
          acc_next = PW'((PW+1)'(acc) + (PW+1)'(len_m));
          m_next   = PW'(sum_m);
          if (sum_m < (PW+1)'(PAGES)) begin
            mreq.en   = 1'b1;
            mreq.addr = sum_m[AW-1:0];
          end else begin
            state_next = S_C_WR;
          end
        end
      end
      S_C_WR: begin
        mreq.en    = 1'b1;
        mreq.we    = 1'b1;
        mreq.addr  = n[AW-1:0];
        mreq.wdata = 8'(acc) & LEN_MASK;
        n_next     = PW'(sum_acc);
        state_next = (sum_acc >= (PW+1)'(PAGES)) ? S_FIN : S_C_RD;
      end
      S_FIN: begin
        if (take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) op_q <= op;
    hdl      <= hdl_next;
    req      <= req_next;
    n        <= n_next;
    m        <= m_next;
    acc      <= acc_next;
    wr2_addr <= wr2_addr_next;
    wr2_data <= wr2_data_next;
    res_hdl  <= res_hdl_next;
    status   <= status_next;
  end

  assign sts.idle   = (state == S_IDLE);
  assign sts.done   = (state == S_FIN);
  assign res.handle = res_hdl;
  assign res.status = status;
  assign res.count  = count;

endmodule
`default_nettype wire

FILE: rtl/core/packet_page_allocator.sv
`default_nettype none
// First-fit page allocator for a packet buffer of PAGES 256-byte pages. Each
// word carries op (0 allocate, 1 shrink, 2 free), handle and a byte length and
// gets back one word: result_handle, status and the live packet count. The
// span map sits in a single-port RAM with a registered read, one access a
// cycle. Allocate reads and checks each head it walks, then writes the new
// head, plus the remainder head for a split. Shrink and free read and rewrite
// the head (a shrink also writes the remainder head for a split) and run a
// coalesce pass over the whole map that skips used heads and merges each free
// run of spans into one head, then hand the word over. A shrink that does not
// shrink skips the pass. Bad or none handles go straight to the finish state.
// No clearing pass after reset: per-page valid flops make unwritten pages
// read as the reset map. A finished word waits in the output register while
// the next word is taken.
module packet_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  handle,
  input  wire logic [15:0] length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       result_handle,
  output logic [1:0]       status,
  output logic [6:0]       packet_count
);
  import ppa_pkg::*;

  ppa_mreq_t mreq;
  ppa_sts_t  sts;
  ppa_res_t  res;
  logic [7:0] rdata;
  logic       start;
  logic       take;

  // sequencer takes a new word only when idle
  assign in_stall = !sts.idle;
  assign start    = in_valid && !in_stall;
  // hand the result over once the output register is free
  assign take     = sts.done && (!out_valid || !out_stall);

  ppa_map u_map (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (rdata)
  );

  ppa_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .handle (handle),
    .length (length),
    .take   (take),
    .rdata  (rdata),
    .mreq   (mreq),
    .sts    (sts),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_handle <= res.handle;
      status        <= res.status;
      packet_count  <= res.count;
    end
  end

  // a taken word keeps the sequencer busy the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> in_stall)
    else $error("accepted word did not occupy the sequencer");

  // a real handle only comes with ok status and lies inside the buffer
  a_handle_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_handle != NO_HANDLE) |->
      (status == ST_OK && result_handle < 8'(PAGES)))
    else $error("allocated handle with bad status or out of range");

  // no-space result never carries a handle
  a_nospace: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NOSPACE) |-> result_handle == NO_HANDLE)
    else $error("no-space result carries a handle");

endmodule
`default_nettype wire
